// ===== rtl/rpnsc_pkg.sv =====
package rpnsc_pkg;

  localparam logic [2:0] OPC_PUSH = 3'd0;
  localparam logic [2:0] OPC_ADD  = 3'd1;
  localparam logic [2:0] OPC_SUB  = 3'd2;
  localparam logic [2:0] OPC_MUL  = 3'd3;
  localparam logic [2:0] OPC_DIV  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  localparam int UPC_W = 5;

  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [3:0] act_t;
  typedef logic [3:0] cond_t;

  // datapath actions
  localparam act_t A_NOP    = 4'd0;
  localparam act_t A_ACCEPT = 4'd1;
  localparam act_t A_LOADOP = 4'd2;
  localparam act_t A_ADDSUB = 4'd3;
  localparam act_t A_MUL    = 4'd4;
  localparam act_t A_MULSH  = 4'd5;
  localparam act_t A_DINIT  = 4'd6;
  localparam act_t A_DSTEP  = 4'd7;
  localparam act_t A_DFIN   = 4'd8;
  localparam act_t A_WRITE  = 4'd9;
  localparam act_t A_PUSH   = 4'd10;
  localparam act_t A_OVF    = 4'd11;
  localparam act_t A_UDF    = 4'd12;
  localparam act_t A_DZ     = 4'd13;
  localparam act_t A_EMIT   = 4'd14;

  // jump conditions
  localparam cond_t C_NEVER   = 4'd0;
  localparam cond_t C_ALWAYS  = 4'd1;
  localparam cond_t C_INVALID = 4'd2;
  localparam cond_t C_PUSH    = 4'd3;
  localparam cond_t C_BADOP   = 4'd4;
  localparam cond_t C_UNDER   = 4'd5;
  localparam cond_t C_MUL     = 4'd6;
  localparam cond_t C_DIV     = 4'd7;
  localparam cond_t C_RHSZ    = 4'd8;
  localparam cond_t C_DBUSY   = 4'd9;
  localparam cond_t C_FULL    = 4'd10;
  localparam cond_t C_OUTFREE = 4'd11;

  // program addresses
  localparam upc_t U_WAIT    = 5'd0;
  localparam upc_t U_DEC     = 5'd1;
  localparam upc_t U_BADOP   = 5'd2;
  localparam upc_t U_UNDCHK  = 5'd3;
  localparam upc_t U_RDSEC   = 5'd4;
  localparam upc_t U_LOADOP  = 5'd5;
  localparam upc_t U_DIVCHK  = 5'd6;
  localparam upc_t U_ADDSUB  = 5'd7;
  localparam upc_t U_MUL     = 5'd8;
  localparam upc_t U_MULSH   = 5'd9;
  localparam upc_t U_DIV     = 5'd10;
  localparam upc_t U_DINIT   = 5'd11;
  localparam upc_t U_DSTEP   = 5'd12;
  localparam upc_t U_DFIN    = 5'd13;
  localparam upc_t U_WRITE   = 5'd14;
  localparam upc_t U_PUSHCHK = 5'd15;
  localparam upc_t U_PUSH    = 5'd16;
  localparam upc_t U_OVF     = 5'd17;
  localparam upc_t U_UDF     = 5'd18;
  localparam upc_t U_DZ      = 5'd19;
  localparam upc_t U_EMIT    = 5'd20;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    logic  hold;
    upc_t  target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    unique case (addr)
      U_WAIT:    w = '{act: A_ACCEPT, cond: C_INVALID, hold: 1'b1, target: U_DEC};
      U_DEC:     w = '{act: A_NOP,    cond: C_PUSH,    hold: 1'b0, target: U_PUSHCHK};
      U_BADOP:   w = '{act: A_NOP,    cond: C_BADOP,   hold: 1'b0, target: U_EMIT};
      U_UNDCHK:  w = '{act: A_NOP,    cond: C_UNDER,   hold: 1'b0, target: U_UDF};
      U_RDSEC:   w = '{act: A_NOP,    cond: C_NEVER,   hold: 1'b0, target: U_WAIT};
      U_LOADOP:  w = '{act: A_LOADOP, cond: C_MUL,     hold: 1'b0, target: U_MUL};
      U_DIVCHK:  w = '{act: A_NOP,    cond: C_DIV,     hold: 1'b0, target: U_DIV};
      U_ADDSUB:  w = '{act: A_ADDSUB, cond: C_ALWAYS,  hold: 1'b0, target: U_WRITE};
      U_MUL:     w = '{act: A_MUL,    cond: C_NEVER,   hold: 1'b0, target: U_WAIT};
      U_MULSH:   w = '{act: A_MULSH,  cond: C_ALWAYS,  hold: 1'b0, target: U_WRITE};
      U_DIV:     w = '{act: A_NOP,    cond: C_RHSZ,    hold: 1'b0, target: U_DZ};
      U_DINIT:   w = '{act: A_DINIT,  cond: C_NEVER,   hold: 1'b0, target: U_WAIT};
      U_DSTEP:   w = '{act: A_DSTEP,  cond: C_DBUSY,   hold: 1'b0, target: U_DSTEP};
      U_DFIN:    w = '{act: A_DFIN,   cond: C_NEVER,   hold: 1'b0, target: U_WAIT};
      U_WRITE:   w = '{act: A_WRITE,  cond: C_ALWAYS,  hold: 1'b0, target: U_EMIT};
      U_PUSHCHK: w = '{act: A_NOP,    cond: C_FULL,    hold: 1'b0, target: U_OVF};
      U_PUSH:    w = '{act: A_PUSH,   cond: C_ALWAYS,  hold: 1'b0, target: U_EMIT};
      U_OVF:     w = '{act: A_OVF,    cond: C_ALWAYS,  hold: 1'b0, target: U_EMIT};
      U_UDF:     w = '{act: A_UDF,    cond: C_ALWAYS,  hold: 1'b0, target: U_EMIT};
      U_DZ:      w = '{act: A_DZ,     cond: C_ALWAYS,  hold: 1'b0, target: U_EMIT};
      U_EMIT:    w = '{act: A_EMIT,   cond: C_OUTFREE, hold: 1'b1, target: U_WAIT};
      default:   w = '{act: A_NOP,    cond: C_ALWAYS,  hold: 1'b0, target: U_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/rpn_stack_calculator_top.sv =====
// Reverse-Polish calculator on a stack of STACK_DEPTH signed fixed-point values with FRAC_BITS
// fraction bits. Each input transaction pushes in_push_value or pops two operands, combines
// them (the older entry on the left) and pushes the saturated answer; a push to a full
// stack, an operation on fewer than two entries, a divide by zero and an unknown opcode leave
// the stack as it is. Every input transaction gives one output transaction with the new top,
// the depth and a status. A small microcode program steps a single datapath and one write
// port and one read port of the stack memory; the restoring divider forms one quotient bit
// per cycle. A finished result waits in the output register while the next transaction is
// taken.
module rpn_stack_calculator_top
  import rpnsc_pkg::*;
#(
  parameter int STACK_DEPTH = 128,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_top_value,
  output logic [7:0]         out_stack_depth,
  output logic [2:0]         out_status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  upc_t   upc_r, upc_nxt;
  ucode_t uw;
  logic   cond_true;

  logic [2:0]         op_r;
  logic signed [31:0] val_r;
  logic [PW-1:0]      sp_r;
  logic signed [31:0] top_r;
  logic [2:0]         st_r;
  logic signed [31:0] lhs_r, rhs_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;
  logic               sat_r;

  logic [DW-1:0] dvd_r;
  logic [31:0]   rem_r, dvs_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;

  logic signed [31:0] stack_mem [STACK_DEPTH];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      sec_idx;

  logic               out_valid_r;
  logic signed [31:0] out_top_r;
  logic [7:0]         out_depth_r;
  logic [2:0]         out_status_r;
  logic               out_free;

  logic [32:0]        lhs_x, rhs_x, sum_x;
  logic signed [63:0] mshift;
  logic [63:0]        qext;
  logic [63:0]        wide;
  logic signed [31:0] clamp_val;
  logic               clamp_sat;
  logic [31:0]        lhs_mag, rhs_mag;
  logic [32:0]        trial;
  logic               qbit;

  assign uw       = ucode_rom(upc_r);
  assign in_ready = (uw.act == A_ACCEPT);
  assign out_free = !out_valid_r || out_ready;
  assign sec_idx  = AW'(sp_r - PW'(2));

  always_comb begin
    case (uw.cond)
      C_NEVER:   cond_true = 1'b0;
      C_ALWAYS:  cond_true = 1'b1;
      C_INVALID: cond_true = in_valid;
      C_PUSH:    cond_true = (op_r == OPC_PUSH);
      C_BADOP:   cond_true = (op_r > OPC_DIV);
      C_UNDER:   cond_true = (sp_r < PW'(2));
      C_MUL:     cond_true = (op_r == OPC_MUL);
      C_DIV:     cond_true = (op_r == OPC_DIV);
      C_RHSZ:    cond_true = (rhs_r == 32'sd0);
      C_DBUSY:   cond_true = (cnt_r != CW'(1));
      C_FULL:    cond_true = (sp_r == PW'(STACK_DEPTH));
      C_OUTFREE: cond_true = out_free;
      default:   cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      upc_nxt = uw.target;
    end else if (uw.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // arithmetic
  assign lhs_x  = {lhs_r[31], lhs_r};
  assign rhs_x  = {rhs_r[31], rhs_r};
  assign sum_x  = (op_r == OPC_SUB) ? (lhs_x - rhs_x) : (lhs_x + rhs_x);
  assign mshift = prod_r >>> FRAC_BITS;
  assign qext   = 64'(dvd_r);

  always_comb begin
    case (uw.act)
      A_ADDSUB: wide = {{31{sum_x[32]}}, sum_x};
      A_MULSH:  wide = mshift;
      default:  wide = neg_r ? (~qext + 64'd1) : qext;
    endcase
  end

  always_comb begin
    clamp_sat = (wide[62:31] != {32{wide[63]}});
    if (!clamp_sat) begin
      clamp_val = wide[31:0];
    end else if (wide[63]) begin
      clamp_val = 32'sh8000_0000;
    end else begin
      clamp_val = 32'sh7FFF_FFFF;
    end
  end

  assign lhs_mag = lhs_r[31] ? (~lhs_r + 32'd1) : lhs_r;
  assign rhs_mag = rhs_r[31] ? (~rhs_r + 32'd1) : rhs_r;
  assign trial   = {rem_r, dvd_r[DW-1]};
  assign qbit    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (uw.act == A_ACCEPT && in_valid) begin
      op_r  <= in_opcode;
      val_r <= in_push_value;
    end
    if (uw.act == A_LOADOP) begin
      lhs_r <= rd_data_r;
      rhs_r <= top_r;
    end
    if (uw.act == A_MUL) begin
      prod_r <= lhs_r * rhs_r;
    end
    if (uw.act == A_ADDSUB || uw.act == A_MULSH || uw.act == A_DFIN) begin
      res_r <= clamp_val;
      sat_r <= clamp_sat;
    end
    if (uw.act == A_DINIT) begin
      dvd_r <= DW'(lhs_mag) << FRAC_BITS;
      rem_r <= '0;
      dvs_r <= rhs_mag;
      neg_r <= lhs_r[31] ^ rhs_r[31];
      cnt_r <= CW'(DW);
    end
    if (uw.act == A_DSTEP) begin
      rem_r <= qbit ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
      dvd_r <= {dvd_r[DW-2:0], qbit};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (uw.act == A_PUSH) begin
      stack_mem[sp_r[AW-1:0]] <= val_r;
    end else if (uw.act == A_WRITE) begin
      stack_mem[sec_idx] <= res_r;
    end
    rd_data_r <= stack_mem[sec_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      top_r <= '0;
      st_r  <= ST_OK;
    end else begin
      case (uw.act)
        A_ACCEPT: st_r <= ST_OK;
        A_PUSH: begin
          sp_r  <= sp_r + PW'(1);
          top_r <= val_r;
        end
        A_WRITE: begin
          sp_r  <= sp_r - PW'(1);
          top_r <= res_r;
          st_r  <= sat_r ? ST_SATURATED : ST_OK;
        end
        A_OVF:   st_r <= ST_OVERFLOW;
        A_UDF:   st_r <= ST_UNDERFLOW;
        A_DZ:    st_r <= ST_DIVZERO;
        default: st_r <= st_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.act == A_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.act == A_EMIT && out_free) begin
      out_top_r    <= top_r;
      out_depth_r  <= 8'(sp_r);
      out_status_r <= st_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_status      = out_status_r;

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    uw.act == A_PUSH |-> sp_r < PW'(STACK_DEPTH))
    else $error("push into full stack");

  a_write_pop: assert property (@(posedge clk) disable iff (!rst_n)
    uw.act == A_WRITE |=> sp_r == $past(sp_r) - PW'(1))
    else $error("operation did not drop one entry");

  a_write_operands: assert property (@(posedge clk) disable iff (!rst_n)
    uw.act == A_WRITE |-> sp_r >= PW'(2))
    else $error("operation with fewer than two entries");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    uw.act == A_DSTEP |-> cnt_r != '0)
    else $error("divider stepped past its last bit");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rpnsc_pkg::*;

  localparam int STACK_SLOTS = 128;
  localparam int FRAC = 16;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 100;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam longint WIDE_MAX = 64'sd2147483647;
  localparam longint WIDE_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] top;
    logic [7:0]         depth;
    logic [2:0]         status;
  } calc_result_t;

  class stack_tracker;
    logic signed [31:0] entries [STACK_SLOTS];
    int unsigned depth;
    calc_result_t due_results [$];
    int errors;
    int pushes;
    int operations;
    int status_seen [8];

    function void note_item(input logic [2:0] op, input logic signed [31:0] val);
      calc_result_t r;
      logic [2:0] st;
      longint lhs;
      longint rhs;
      longint res;
      bit commit;
      st = ST_OK;
      if (op == OPC_PUSH) begin
        pushes++;
        if (depth >= STACK_SLOTS) begin
          st = ST_OVERFLOW;
        end else begin
          entries[depth] = val;
          depth++;
        end
      end else if (op <= OPC_DIV) begin
        operations++;
        if (depth < 2) begin
          st = ST_UNDERFLOW;
        end else begin
          rhs = entries[depth-1];
          lhs = entries[depth-2];
          commit = 1'b1;
          res = 0;
          case (op)
            OPC_ADD: res = lhs + rhs;
            OPC_SUB: res = lhs - rhs;
            OPC_MUL: res = (lhs * rhs) >>> FRAC;
            default: begin
              if (rhs == 0) begin
                st = ST_DIVZERO;
                commit = 1'b0;
              end else begin
                res = (lhs * (longint'(1) << FRAC)) / rhs;
              end
            end
          endcase
          if (commit) begin
            if (res > WIDE_MAX) begin
              res = WIDE_MAX;
              st = ST_SATURATED;
            end else if (res < WIDE_MIN) begin
              res = WIDE_MIN;
              st = ST_SATURATED;
            end
            entries[depth-2] = res[31:0];
            depth--;
          end
        end
      end
      r.top = (depth > 0) ? entries[depth-1] : 32'sd0;
      r.depth = depth[7:0];
      r.status = st;
      status_seen[st]++;
      due_results.push_back(r);
    endfunction

    function void check_result(input logic signed [31:0] top, input logic [7:0] dep,
                               input logic [2:0] st);
      calc_result_t e;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result top %h depth %0d status %0d", $time, top, dep, st);
        return;
      end
      e = due_results.pop_front();
      if (top !== e.top) begin
        errors++;
        $display("%0t: top_value expected %h, got %h", $time, e.top, top);
      end
      if (dep !== e.depth) begin
        errors++;
        $display("%0t: stack_depth expected %0d, got %0d", $time, e.depth, dep);
      end
      if (st !== e.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, e.status, st);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_opcode = OPC_PUSH;
  logic signed [31:0] in_push_value = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_top_value;
  logic [7:0]         out_stack_depth;
  logic [2:0]         out_status;

  stack_tracker tracker = new();
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int out_stall_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  rpn_stack_calculator_top #(
    .STACK_DEPTH(STACK_SLOTS),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_top_value  (out_top_value),
    .out_stack_depth(out_stack_depth),
    .out_status     (out_status)
  );

  always #5 clk = ~clk;

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'sd0;
      3: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      4, 5, 6: return int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
      7: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_arith();
    case ($urandom_range(0, 3))
      0: return OPC_ADD;
      1: return OPC_SUB;
      2: return OPC_MUL;
      default: return OPC_DIV;
    endcase
  endfunction

  task automatic send_op(input logic [2:0] op, input logic signed [31:0] val);
    int gap;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_push_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(op, val);
    if (op <= OPC_DIV) items_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_top_value, out_stack_depth, out_status);
    if ($urandom_range(0, 255) == 0) out_calm = !out_calm;
    if (out_stall_left > 0) begin
      out_ready <= 1'b0;
      out_stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) out_stall_left = idle_cycles();
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int kind;
    int len;
    int target;
    int seq_no;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty and single-entry underflow, positive saturation, divide by zero, no-op codes
    send_op(OPC_ADD, 32'sd0);
    send_op(OPC_PUSH, Q_MAX);
    send_op(OPC_SUB, 32'sd0);
    send_op(OPC_PUSH, 32'sd1);
    send_op(OPC_ADD, 32'sd0);
    send_op(OPC_PUSH, Q_MIN);
    send_op(OPC_SUB, 32'sd0);
    send_op(OPC_PUSH, 32'sd0);
    send_op(OPC_DIV, 32'sd0);
    send_op(3'd5, Q_MAX);
    send_op(3'd6, Q_MIN);
    send_op(3'd7, -32'sd1);
    send_op(OPC_MUL, 32'sd0);
    send_op(OPC_PUSH, 32'shFFFC_8000);
    send_op(OPC_PUSH, 32'sh0002_0000);
    send_op(OPC_MUL, 32'sd0);
    send_op(OPC_PUSH, -32'sd1);
    send_op(OPC_PUSH, 32'sh0000_8000);
    send_op(OPC_MUL, 32'sd0);
    send_op(OPC_PUSH, 32'sh0002_0000);
    send_op(OPC_DIV, 32'sd0);
    send_op(OPC_PUSH, Q_MIN);
    send_op(OPC_PUSH, -Q_ONE);
    send_op(OPC_DIV, 32'sd0);
    send_op(OPC_SUB, 32'sd0);

    items_sent = 0;
    seq_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      kind = (seq_no == 0) ? 99 : $urandom_range(0, 99);
      seq_no++;
      if (kind < 50) begin
        len = $urandom_range(4, 24);
        repeat (len) begin
          if (tracker.depth < 2 ||
              (tracker.depth < 40 && $urandom_range(0, 1) == 0))
            send_op(OPC_PUSH, rand_operand());
          else
            send_op(rand_arith(), $urandom);
        end
      end else if (kind < 60) begin
        if (tracker.depth < 1) send_op(OPC_PUSH, rand_operand());
        send_op(OPC_PUSH, 32'sd0);
        send_op(OPC_DIV, $urandom);
      end else if (kind < 72) begin
        send_op(OPC_PUSH, $urandom_range(0, 1) ? Q_MAX : Q_MIN);
        send_op(OPC_PUSH, $urandom_range(0, 1) ? rand_operand() : $urandom);
        send_op(rand_arith(), $urandom);
      end else if (kind < 82) begin
        while (tracker.depth >= 2) send_op(rand_arith(), $urandom);
        len = $urandom_range(1, 2);
        repeat (len) send_op(rand_arith(), $urandom);
      end else if (kind < 98) begin
        len = $urandom_range(1, 6);
        repeat (len) send_op(3'($urandom_range(0, 7)), $urandom);
      end else begin
        while (tracker.depth < STACK_SLOTS) send_op(OPC_PUSH, rand_operand());
        len = $urandom_range(1, 3);
        repeat (len) send_op(OPC_PUSH, $urandom);
        target = $urandom_range(0, 20);
        while (tracker.depth > target && tracker.depth >= 2)
          send_op(($urandom_range(0, 3) == 0) ? OPC_DIV : rand_arith(), $urandom);
      end
    end

    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d pushes and %0d operations with random stalls on both sides.",
             tracker.pushes, tracker.operations);
    $display("Outcomes: ok %0d, overflow %0d, underflow %0d, divide by zero %0d, saturated %0d",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_OVERFLOW],
             tracker.status_seen[ST_UNDERFLOW], tracker.status_seen[ST_DIVZERO],
             tracker.status_seen[ST_SATURATED]);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rpnsc_pkg.sv
rtl/rpn_stack_calculator_top.sv
bench/testbench.sv
